/* rtl/core/sfp_pkg.sv */
// Package for the serial bus frame parser: parse and sequencer state types,
// command and status structs, protocol byte codes and the channel scaling.
// No dependencies.
package sfp_pkg;

   localparam int FRAME_BYTES = 25;
   localparam int CNT_W       = 5;

   localparam logic [7:0] START_SYM   = 8'h0f;
   localparam logic [7:0] END_SBUS    = 8'h00;
   localparam logic [7:0] END_VOLT    = 8'h04;
   localparam logic [7:0] END_GPS     = 8'h14;
   localparam logic [7:0] END_SBUS2_A = 8'h24;
   localparam logic [7:0] END_SBUS2_B = 8'h34;
   localparam logic [7:0] MARK_VOLT   = 8'h03;
   localparam logic [7:0] MARK_GPS    = 8'h13;
   localparam int         VOLT_BYTES  = 3;
   localparam int         GPS_BYTES   = 24;
   localparam int         PROP_CHANNELS = 16;
   localparam int         ALL_CHANNELS  = 18;
   localparam logic [11:0] VALUE_OFFSET = 12'd874;
   localparam logic [11:0] SWITCH_ON    = 12'd1998;
   localparam logic [11:0] SWITCH_OFF   = 12'd998;
   localparam logic [4:0]  MAX_CH_RESET = 5'd18;

   typedef enum logic [2:0] {
      PS_DESYNC, PS_START, PS_SYNC1, PS_SYNC2, PS_VOLT, PS_GPS
   } parse_state_type;

   typedef enum logic [1:0] {
      PH_IDLE, PH_EMIT, PH_SHIFT
   } phase_type;

   typedef enum logic [1:0] {
      CNT_BASE, CNT_INC, CNT_ONE, CNT_ZERO
   } cnt_op_type;

   typedef enum logic [2:0] {
      END_BAD, END_IS_SBUS, END_IS_VOLT, END_IS_GPS, END_IS_SBUS2
   } end_code_type;

   typedef struct packed {
      logic       accept;
      logic       wr_store;
      cnt_op_type cnt_op;
      logic       drop_inc;
      logic       start_shift;
      logic       shift;
      logic       start_emit;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic         full;
      logic         frame_complete;
      logic         start_ok;
      end_code_type end_code;
      logic         b_start;
      logic         first_start;
      logic         volt_done;
      logic         gps_done;
      logic         volt_mark_ok;
      logic         gps_mark_ok;
      logic         shift_hit;
      logic         shift_end;
      logic         emit_last;
      logic         emit_none;
      logic         out_free;
   } status_type;

   // Microsecond scaling of an 11-bit raw channel, rounded half up.
   function automatic logic [11:0] scale_raw(input logic [10:0] raw);
      logic [13:0] prod;
      prod = 14'({raw, 2'b00}) + 14'(raw) + 14'd4;
      return 12'(prod[13:3]) + VALUE_OFFSET;
   endfunction

endpackage

/* rtl/core/sfp_ctrl.sv */
// Sequencer of the frame parser: parse state and work phase, issues commands
// to the datapath. Depends on sfp_pkg.
module sfp_ctrl
   import sfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   parse_state_type ps_ff, ps_in, ps_eff;
   phase_type       phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_ff    <= PS_DESYNC;
         phase_ff <= PH_IDLE;
      end else begin
         ps_ff    <= ps_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      ps_in     = ps_ff;
      phase_in  = phase_ff;
      cmd       = '0;
      cmd.cnt_op = CNT_BASE;
      req_ready = (phase_ff == PH_IDLE);
      ps_eff    = status.full ? PS_DESYNC : ps_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               ps_in      = ps_eff;
               unique case (ps_eff)
                  PS_START, PS_SYNC1, PS_SYNC2: begin
                     cmd.wr_store = 1'b1;
                     cmd.cnt_op   = CNT_INC;
                     if (status.frame_complete) begin
                        cmd.cnt_op = CNT_ZERO;
                        if (!status.start_ok) begin
                           cmd.drop_inc    = 1'b1;
                           ps_in           = PS_DESYNC;
                           phase_in        = PH_SHIFT;
                           cmd.start_shift = 1'b1;
                        end else begin
                           unique case (status.end_code)
                              END_IS_SBUS:  ps_in = PS_SYNC1;
                              END_IS_VOLT:  ps_in = PS_VOLT;
                              END_IS_GPS:   ps_in = PS_GPS;
                              END_IS_SBUS2: ps_in = PS_SYNC2;
                              default:      ps_in = PS_DESYNC;
                           endcase
                           if (status.end_code == END_BAD) begin
                              phase_in        = PH_SHIFT;
                              cmd.start_shift = 1'b1;
                           end else if (!status.emit_none) begin
                              phase_in       = PH_EMIT;
                              cmd.start_emit = 1'b1;
                           end
                        end
                     end
                  end
                  PS_VOLT, PS_GPS: begin
                     cmd.wr_store = 1'b1;
                     cmd.cnt_op   = CNT_INC;
                     if (status.first_start) ps_in = PS_SYNC2;
                     if ((ps_eff == PS_VOLT) ? status.volt_done : status.gps_done) begin
                        if ((ps_eff == PS_VOLT) ? status.volt_mark_ok
                                                : status.gps_mark_ok) begin
                           cmd.cnt_op = CNT_ZERO;
                        end else begin
                           ps_in        = PS_DESYNC;
                           cmd.drop_inc = 1'b1;
                        end
                     end
                  end
                  default: begin
                     ps_in = PS_DESYNC;
                     if (status.b_start) begin
                        cmd.wr_store = 1'b1;
                        cmd.cnt_op   = CNT_ONE;
                        ps_in        = PS_START;
                     end
                  end
               endcase
            end
         end
         PH_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_last) phase_in = PH_IDLE;
            end
         end
         PH_SHIFT: begin
            cmd.shift = 1'b1;
            if (status.shift_hit) begin
               ps_in    = PS_START;
               phase_in = PH_IDLE;
            end else if (status.shift_end) begin
               ps_in    = PS_DESYNC;
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

endmodule

/* rtl/core/sfp_datapath.sv */
// Datapath of the frame parser: frame store, counters, channel register and
// the result register. Depends on sfp_pkg.
module sfp_datapath
   import sfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [7:0]  req_rx_byte,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_channel_index,
   output logic [11:0] rsp_channel_value,
   output logic        rsp_failsafe,
   output logic        rsp_frame_lost,
   output logic [15:0] rsp_drop_count,
   output logic        rsp_last_channel
);

   logic [7:0]       store_ff [FRAME_BYTES];
   logic [CNT_W-1:0] cnt_ff, cnt_in, base, widx;
   logic [15:0]      drop_ff;
   logic [4:0]       shift_ff, ch_ff, max_ch_ff, total, prop_cnt;
   logic [175:0]     chan_bits;
   logic [10:0]      raw;
   logic [11:0]      value;
   logic             rsp_valid_ff;
   logic [4:0]       idx_ff;
   logic [11:0]      val_ff;
   logic             fs_ff, fl_ff, last_ff;
   logic [15:0]      drop_out_ff;
   logic [7:0]       flags;
   logic             fs, fl;

   assign base  = status.full ? '0 : cnt_ff;
   assign widx  = (cmd.cnt_op == CNT_ONE) ? '0 : base;
   assign flags = store_ff[FRAME_BYTES-2];
   assign fs    = flags[3];
   assign fl    = flags[3] | flags[2];

   assign prop_cnt = (max_ch_ff > 5'(PROP_CHANNELS)) ? 5'(PROP_CHANNELS) : max_ch_ff;
   assign total    = (max_ch_ff > 5'(ALL_CHANNELS - 1)) ? 5'(ALL_CHANNELS) : prop_cnt;

   always_comb begin
      for (int i = 0; i < 22; i++) chan_bits[i*8 +: 8] = store_ff[i+1];
   end
   assign raw   = chan_bits[{ch_ff[3:0], 3'b000} + {ch_ff[3:0], 1'b0} + 8'(ch_ff[3:0]) +: 11];
   always_comb begin
      case (ch_ff)
         5'd16:   value = flags[0] ? SWITCH_ON : SWITCH_OFF;
         5'd17:   value = flags[1] ? SWITCH_ON : SWITCH_OFF;
         default: value = scale_raw(raw);
      endcase
   end

   always_comb begin
      status.full           = (cnt_ff >= 5'(FRAME_BYTES));
      status.frame_complete = (base == 5'(FRAME_BYTES - 1));
      status.start_ok       = (store_ff[0] == START_SYM);
      case (req_rx_byte)
         END_SBUS:                 status.end_code = END_IS_SBUS;
         END_VOLT:                 status.end_code = END_IS_VOLT;
         END_GPS:                  status.end_code = END_IS_GPS;
         END_SBUS2_A, END_SBUS2_B: status.end_code = END_IS_SBUS2;
         default:                  status.end_code = END_BAD;
      endcase
      status.b_start      = (req_rx_byte == START_SYM);
      status.first_start  = (base == '0) && (req_rx_byte == START_SYM);
      status.volt_done    = (base >= 5'(VOLT_BYTES - 1));
      status.gps_done     = (base >= 5'(GPS_BYTES - 1));
      // The first slot byte is the one being written when the count is zero.
      status.volt_mark_ok = (((base == '0) ? req_rx_byte : store_ff[0]) == MARK_VOLT);
      status.gps_mark_ok  = (((base == '0) ? req_rx_byte : store_ff[0]) == MARK_GPS);
      status.shift_hit    = (store_ff[1] == START_SYM);
      status.shift_end    = (shift_ff == 5'(FRAME_BYTES - 2));
      status.emit_last    = (ch_ff + 5'd1 == total);
      status.emit_none    = (total == '0);
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.accept) begin
         case (cmd.cnt_op)
            CNT_INC:  cnt_in = base + 5'd1;
            CNT_ONE:  cnt_in = 5'd1;
            CNT_ZERO: cnt_in = '0;
            default:  cnt_in = base;
         endcase
      end else if (cmd.shift) begin
         // After shifting, the new start byte sits at entry zero.
         if (status.shift_hit)      cnt_in = 5'(FRAME_BYTES - 1) - shift_ff;
         else if (status.shift_end) cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && cmd.wr_store) store_ff[widx] <= req_rx_byte;
      else if (cmd.shift) begin
         for (int i = 0; i < FRAME_BYTES - 1; i++) store_ff[i] <= store_ff[i+1];
      end
      if (cmd.start_shift) shift_ff <= '0;
      else if (cmd.shift)  shift_ff <= shift_ff + 5'd1;
      if (cmd.start_emit) ch_ff <= '0;
      else if (cmd.emit)  ch_ff <= ch_ff + 5'd1;
      if (cmd.emit) begin
         idx_ff      <= ch_ff;
         val_ff      <= value;
         fs_ff       <= fs;
         fl_ff       <= fl;
         last_ff     <= status.emit_last;
         drop_out_ff <= drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         drop_ff      <= '0;
         max_ch_ff    <= MAX_CH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.drop_inc) drop_ff <= drop_ff + 16'd1;
         if (csr_wr_en) max_ch_ff <= csr_wr_data;
         if (cmd.emit)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_index = idx_ff;
   assign rsp_channel_value = val_ff;
   assign rsp_failsafe      = fs_ff;
   assign rsp_frame_lost    = fl_ff;
   assign rsp_drop_count    = drop_out_ff;
   assign rsp_last_channel  = last_ff;

endmodule

/* rtl/core/sbus_frame_parser.sv */
// Serial bus receiver frame parser, top level: joins sequencer and datapath.
// Depends on sfp_pkg, sfp_ctrl and sfp_datapath.
//
// Usage: one received byte is taken per request on req_valid/req_ready.
// Bytes are gathered into a 25-byte frame after a 0x0f start byte. A good
// frame gives up to 18 channel results on rsp_valid/rsp_ready, one per cycle
// while the receiver takes them, the final one marked by rsp_last_channel.
// After the closing byte the sequencer enters its emit phase, and each result
// is loaded into the result register before it is shown. A byte that does
// not close a frame is taken without holding the input. A good frame holds
// the input until all its results (up to 18) are loaded. A bad frame runs
// a byte-wise search of the store for a new start byte, at most 24 positions.
// csr_wr_en/csr_wr_data set the channel count; write it only while idle.
// A stalled receiver holds the current result and halts emission; input
// requests wait until all results of the frame have been loaded.
// Reset: parser hunts for a start byte, drop counter zero, channel count 18.
// The frame store itself is not cleared.
module sbus_frame_parser
   import sfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_channel_index,
   output logic [11:0] rsp_channel_value,
   output logic        rsp_failsafe,
   output logic        rsp_frame_lost,
   output logic [15:0] rsp_drop_count,
   output logic        rsp_last_channel
);

   cmd_type    cmd;
   status_type status;

   sfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sfp_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_rx_byte       (req_rx_byte),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_failsafe      (rsp_failsafe),
      .rsp_frame_lost    (rsp_frame_lost),
      .rsp_drop_count    (rsp_drop_count),
      .rsp_last_channel  (rsp_last_channel)
   );

`ifndef SYNTHESIS
   // While a non-final result is held, the frame is still being emitted.
   a_no_req_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_channel |-> !req_ready)
      else $error("request taken while frame results are pending");

   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_channel_value >= 12'd874 && rsp_channel_value <= 12'd2153
                    && rsp_channel_index <= 5'd17)
      else $error("result outside channel range");

   // The drop counter reported within one frame cannot change.
   a_drop_steady: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_channel ##1 rsp_valid
      |-> rsp_drop_count == $past(rsp_drop_count))
      else $error("drop count changed within a frame");
`endif

endmodule

/* tb/tb_top.sv */
// Testbench for sbus_frame_parser: drives serial bytes, predicts channel results
// and compares them field by field. Depends on sfp_pkg and the parser RTL.
module tb_top;
   import sfp_pkg::*;

   typedef struct {
      logic [4:0]  index;
      logic [11:0] value;
      logic        failsafe;
      logic        frame_lost;
      logic [15:0] drops;
      logic        last;
   } channel_result_type;

   // Tracks the parser state and holds the channel results still owed.
   class channel_scoreboard;
      parse_state_type    state;
      logic [7:0]         store[FRAME_BYTES];
      int                 count;
      logic [15:0]        drops;
      logic [4:0]         max_ch;
      channel_result_type pending[$];
      int                 errors;
      int                 frames;
      int                 results;

      function void clear();
         state = PS_DESYNC;
         count = 0;
         drops = 0;
         max_ch = MAX_CH_RESET;
         errors = 0;
         frames = 0;
         results = 0;
         foreach (store[i]) store[i] = 0;
      endfunction

      function logic [10:0] raw_field(int ch);
         int bitpos;
         int b;
         logic [23:0] w;
         bitpos = ch * 11;
         b = 1 + bitpos / 8;
         w = {store[b + 2], store[b + 1], store[b]};
         return 11'(w >> (bitpos % 8));
      endfunction

      function void add(logic [4:0] ch, logic [11:0] v, logic fs, logic fl, logic lst);
         channel_result_type r;
         r.index = ch; r.value = v; r.failsafe = fs; r.frame_lost = fl;
         r.drops = drops; r.last = lst;
         pending.push_back(r);
      endfunction

      // Returns 1 when the full store decoded as a good frame.
      function bit decode_store();
         logic [7:0] flags;
         logic fs;
         logic fl;
         int cnt;
         int total;
         bit sw;
         logic [13:0] prod;
         if (store[0] != START_SYM) begin
            drops++;
            state = PS_DESYNC;
            return 0;
         end
         case (store[FRAME_BYTES - 1])
            END_SBUS: state = PS_SYNC1;
            END_VOLT: state = PS_VOLT;
            END_GPS: state = PS_GPS;
            END_SBUS2_A, END_SBUS2_B: state = PS_SYNC2;
            default: begin
               state = PS_DESYNC;
               return 0;
            end
         endcase
         frames++;
         flags = store[23];
         fs = flags[3];
         fl = flags[3] | flags[2];
         cnt = (max_ch > PROP_CHANNELS) ? PROP_CHANNELS : max_ch;
         sw = (max_ch > 17) && (cnt > 15);
         total = sw ? ALL_CHANNELS : cnt;
         for (int ch = 0; ch < cnt; ch++) begin
            prod = 14'(raw_field(ch)) * 14'd5 + 14'd4;
            add(5'(ch), 12'(prod >> 3) + 12'd874, fs, fl, (ch + 1 == total));
         end
         if (sw) begin
            add(5'd16, flags[0] ? 12'd1998 : 12'd998, fs, fl, 1'b0);
            add(5'd17, flags[1] ? 12'd1998 : 12'd998, fs, fl, 1'b1);
         end
         return 1;
      endfunction

      function void note_byte(logic [7:0] b);
         int idx;
         int need;
         logic [7:0] marker;
         if (count >= FRAME_BYTES) begin
            count = 0;
            state = PS_DESYNC;
         end
         case (state)
            PS_START, PS_SYNC1, PS_SYNC2: begin
               store[count++] = b;
               if (count >= FRAME_BYTES) begin
                  idx = 0;
                  if (!decode_store()) begin
                     for (int i = 1; i < FRAME_BYTES; i++)
                        if (store[i] == START_SYM && idx == 0) idx = i;
                     if (idx != 0) begin
                        for (int i = 0; i < FRAME_BYTES - idx; i++)
                           store[i] = store[i + idx];
                        count = FRAME_BYTES - idx;
                        state = PS_START;
                     end
                  end
                  if (idx == 0) count = 0;
               end
            end
            PS_VOLT, PS_GPS: begin
               need = (state == PS_VOLT) ? VOLT_BYTES : GPS_BYTES;
               marker = (state == PS_VOLT) ? MARK_VOLT : MARK_GPS;
               store[count++] = b;
               if (count == 1 && store[0] == START_SYM) state = PS_SYNC2;
               if (count >= need) begin
                  if (store[0] == marker) count = 0;
                  else begin
                     state = PS_DESYNC;
                     drops++;
                  end
               end
            end
            default: begin
               state = PS_DESYNC;
               if (b == START_SYM) begin
                  state = PS_START;
                  store[0] = b;
                  count = 1;
               end
            end
         endcase
      endfunction

      function void check(channel_result_type got);
         channel_result_type want;
         results++;
         if (pending.size() == 0) begin
            $error("unexpected result: channel %0d value %0d", got.index, got.value);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.index !== want.index) begin
            $error("channel_index: expected %0d, got %0d", want.index, got.index);
            errors++;
         end
         if (got.value !== want.value) begin
            $error("channel_value: expected %0d, got %0d", want.value, got.value);
            errors++;
         end
         if (got.failsafe !== want.failsafe) begin
            $error("failsafe: expected %0d, got %0d", want.failsafe, got.failsafe);
            errors++;
         end
         if (got.frame_lost !== want.frame_lost) begin
            $error("frame_lost: expected %0d, got %0d", want.frame_lost, got.frame_lost);
            errors++;
         end
         if (got.drops !== want.drops) begin
            $error("drop_count: expected %0d, got %0d", want.drops, got.drops);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last_channel: expected %0d, got %0d", want.last, got.last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 0;
   logic        csr_wr_en = 0;
   logic [4:0]  csr_wr_data = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [4:0]  rsp_channel_index;
   logic [11:0] rsp_channel_value;
   logic        rsp_failsafe;
   logic        rsp_frame_lost;
   logic [15:0] rsp_drop_count;
   logic        rsp_last_channel;

   channel_scoreboard sb;
   bit  hold_off = 0;
   int  burst_left = 0;
   int  byte_total = 0;

   sbus_frame_parser DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_rx_byte(req_rx_byte),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_channel_index(rsp_channel_index), .rsp_channel_value(rsp_channel_value),
      .rsp_failsafe(rsp_failsafe), .rsp_frame_lost(rsp_frame_lost),
      .rsp_drop_count(rsp_drop_count), .rsp_last_channel(rsp_last_channel)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Receiver: stalls on its own pattern, with an occasional long hold-off.
   always @(posedge clock) begin
      channel_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.index = rsp_channel_index; got.value = rsp_channel_value;
         got.failsafe = rsp_failsafe; got.frame_lost = rsp_frame_lost;
         got.drops = rsp_drop_count; got.last = rsp_last_channel;
         sb.check(got);
      end
      if (hold_off) rsp_ready <= 0;
      else rsp_ready <= ($urandom_range(0, 3) != 0) || (($urandom & 32'h700) == 0);
   end

   // Drops the request line and waits for a clock edge.
   task automatic stop_sending();
      req_valid <= 0;
      burst_left = 0;
      @(posedge clock);
   endtask

   // Sends one byte; the sender may idle between bursts of random length.
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(b);
      byte_total++;
   endtask

   task automatic send_frame(input logic [7:0] end_byte, input logic [7:0] flags,
                             input int fill);
      send_byte(START_SYM);
      for (int i = 1; i <= 22; i++)
         case (fill)
            0: send_byte(8'h00);
            1: send_byte(8'hff);
            default: send_byte(8'($urandom));
         endcase
      send_byte(flags);
      send_byte(end_byte);
   endtask

   task automatic send_slot(input logic [7:0] marker, input int len);
      for (int i = 0; i < len; i++) send_byte(i == 0 ? marker : 8'($urandom));
   endtask

   task automatic drain_and_idle();
      int guard;
      guard = 0;
      stop_sending();
      @(posedge clock);
      while ((sb.pending.size() != 0 || req_ready !== 1) && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   task automatic write_channels(input logic [4:0] n);
      drain_and_idle();
      csr_wr_en <= 1;
      csr_wr_data <= n;
      @(posedge clock);
      sb.max_ch = n;
      csr_wr_en <= 0;
   endtask

   task automatic random_item();
      int pick;
      logic [7:0] ends[5];
      ends = '{END_SBUS, END_VOLT, END_GPS, END_SBUS2_A, END_SBUS2_B};
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         send_frame(ends[$urandom_range(0, 4)], 8'($urandom), 2);
         // Follow a slot-announcing frame with its slot, mostly well formed.
         if (sb.state == PS_VOLT)
            send_slot(($urandom_range(0, 4) == 0) ? 8'($urandom) : MARK_VOLT, VOLT_BYTES);
         else if (sb.state == PS_GPS)
            send_slot(($urandom_range(0, 4) == 0) ? START_SYM : MARK_GPS, GPS_BYTES);
      end else if (pick == 7) begin
         // Broken frame, often with a start byte inside, exercising the recovery shift.
         send_byte(START_SYM);
         for (int i = 1; i < FRAME_BYTES; i++)
            send_byte(($urandom_range(0, 8) == 0) ? START_SYM : 8'($urandom));
      end else begin
         repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: field extremes, end bytes, flag bits, slots.
      send_byte(8'h00);
      send_byte(8'hff);
      send_frame(END_SBUS, 8'h00, 0);
      send_frame(END_SBUS2_A, 8'h0f, 1);
      send_frame(END_VOLT, 8'h04, 2);
      send_slot(MARK_VOLT, VOLT_BYTES);
      send_frame(END_GPS, 8'h08, 2);
      send_slot(MARK_GPS, GPS_BYTES);
      send_frame(END_VOLT, 8'h01, 2);
      send_slot(8'h55, VOLT_BYTES);
      send_frame(END_GPS, 8'h02, 2);
      send_slot(START_SYM, 1);
      send_frame(8'h77, 8'h00, 2);

      write_channels(5'd1);
      send_frame(END_SBUS, 8'($urandom), 2);
      write_channels(5'd0);
      send_frame(END_SBUS, 8'h0c, 2);
      write_channels(5'd31);
      send_frame(END_SBUS2_A, 8'h0d, 2);
      write_channels(5'd17);
      send_frame(END_SBUS, 8'h0b, 2);

      // Long receiver hold-off while frames keep coming.
      write_channels(5'd18);
      hold_off = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         begin
            send_frame(END_SBUS2_B, 8'($urandom), 2);
            send_frame(END_SBUS, 8'($urandom), 2);
            stop_sending();
         end
      join

      random_item();

      drain_and_idle();
      $display("Sent %0d bytes, %0d good frames decoded, %0d channel results checked,",
               byte_total, sb.frames, sb.results);
      $display("%0d frames dropped.", sb.drops);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         if (sb.pending.size() != 0)
            $error("%0d expected results never arrived", sb.pending.size());
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("status: fail");
      $finish;
   end
endmodule
